FILE: rtl/rkc_pkg.sv
// Shared types, constants and rule table functions for the romaji to kana converter.
package rkc_pkg;

    localparam int WINDOW_DEPTH_DEF = 4;
    localparam int QUEUE_DEPTH_DEF  = 2;

    localparam logic [15:0] KANA_N      = 16'h3093;
    localparam logic [15:0] KANA_SOKUON = 16'h3063;

    localparam logic [6:0] CH_N    = 7'h6e;
    localparam logic [6:0] CH_Y    = 7'h79;
    localparam logic [6:0] CH_APOS = 7'h27;

    typedef enum logic [1:0] {
        CMD_REJECT = 2'd0,
        CMD_LETTER = 2'd1,
        CMD_FLUSH  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] code;
    } cmd_t;

    typedef struct packed {
        logic        hit;
        logic [15:0] k0;
        logic [15:0] k1;
    } rom_hit_t;

    typedef struct packed {
        logic        go;
        logic [15:0] k0;
        logic [15:0] k1;
        logic [2:0]  use_n;
    } settle_t;

    function automatic logic is_vowel(input logic [6:0] c);
        return c == 7'h61 || c == 7'h69 || c == 7'h75 || c == 7'h65 || c == 7'h6f;
    endfunction

    function automatic logic doubles(input logic [6:0] c);
        return c >= 7'h61 && c <= 7'h7a && !is_vowel(c) && c != CH_N;
    endfunction

    function automatic rom_hit_t mk(input logic [15:0] a, input logic [15:0] b);
        rom_hit_t r;
        r.hit = 1'b1;
        r.k0  = a;
        r.k1  = b;
        return r;
    endfunction

    // Key holds the letters right-justified, eight bits each, first letter highest.
    function automatic rom_hit_t rom_lookup(input logic [31:0] key);
        rom_hit_t r;
        r = '0;
        case (key)
            "kya": r = mk(16'h304D, 16'h3083); "kyi": r = mk(16'h304D, 16'h3043);
            "kyu": r = mk(16'h304D, 16'h3085); "kye": r = mk(16'h304D, 16'h3047);
            "kyo": r = mk(16'h304D, 16'h3087);
            "gya": r = mk(16'h304E, 16'h3083); "gyi": r = mk(16'h304E, 16'h3043);
            "gyu": r = mk(16'h304E, 16'h3085); "gye": r = mk(16'h304E, 16'h3047);
            "gyo": r = mk(16'h304E, 16'h3087);
            "sya": r = mk(16'h3057, 16'h3083); "syi": r = mk(16'h3057, 16'h3043);
            "syu": r = mk(16'h3057, 16'h3085); "sye": r = mk(16'h3057, 16'h3047);
            "syo": r = mk(16'h3057, 16'h3087);
            "jya": r = mk(16'h3058, 16'h3083); "jyi": r = mk(16'h3058, 16'h3043);
            "jyu": r = mk(16'h3058, 16'h3085); "jye": r = mk(16'h3058, 16'h3047);
            "jyo": r = mk(16'h3058, 16'h3087);
            "zya": r = mk(16'h3058, 16'h3083); "zyi": r = mk(16'h3058, 16'h3043);
            "zyu": r = mk(16'h3058, 16'h3085); "zye": r = mk(16'h3058, 16'h3047);
            "zyo": r = mk(16'h3058, 16'h3087);
            "cya": r = mk(16'h3061, 16'h3083); "cyi": r = mk(16'h3061, 16'h3043);
            "cyu": r = mk(16'h3061, 16'h3085); "cye": r = mk(16'h3061, 16'h3047);
            "cyo": r = mk(16'h3061, 16'h3087);
            "tya": r = mk(16'h3061, 16'h3083); "tyi": r = mk(16'h3061, 16'h3043);
            "tyu": r = mk(16'h3061, 16'h3085); "tye": r = mk(16'h3061, 16'h3047);
            "tyo": r = mk(16'h3061, 16'h3087);
            "dya": r = mk(16'h3062, 16'h3083); "dyi": r = mk(16'h3062, 16'h3043);
            "dyu": r = mk(16'h3062, 16'h3085); "dye": r = mk(16'h3062, 16'h3047);
            "dyo": r = mk(16'h3062, 16'h3087);
            "nya": r = mk(16'h306B, 16'h3083); "nyi": r = mk(16'h306B, 16'h3043);
            "nyu": r = mk(16'h306B, 16'h3085); "nye": r = mk(16'h306B, 16'h3047);
            "nyo": r = mk(16'h306B, 16'h3087);
            "hya": r = mk(16'h3072, 16'h3083); "hyi": r = mk(16'h3072, 16'h3043);
            "hyu": r = mk(16'h3072, 16'h3085); "hye": r = mk(16'h3072, 16'h3047);
            "hyo": r = mk(16'h3072, 16'h3087);
            "bya": r = mk(16'h3073, 16'h3083); "byi": r = mk(16'h3073, 16'h3043);
            "byu": r = mk(16'h3073, 16'h3085); "bye": r = mk(16'h3073, 16'h3047);
            "byo": r = mk(16'h3073, 16'h3087);
            "pya": r = mk(16'h3074, 16'h3083); "pyi": r = mk(16'h3074, 16'h3043);
            "pyu": r = mk(16'h3074, 16'h3085); "pye": r = mk(16'h3074, 16'h3047);
            "pyo": r = mk(16'h3074, 16'h3087);
            "mya": r = mk(16'h307F, 16'h3083); "myi": r = mk(16'h307F, 16'h3043);
            "myu": r = mk(16'h307F, 16'h3085); "mye": r = mk(16'h307F, 16'h3047);
            "myo": r = mk(16'h307F, 16'h3087);
            "rya": r = mk(16'h308A, 16'h3083); "ryi": r = mk(16'h308A, 16'h3043);
            "ryu": r = mk(16'h308A, 16'h3085); "rye": r = mk(16'h308A, 16'h3047);
            "ryo": r = mk(16'h308A, 16'h3087);
            "sha": r = mk(16'h3057, 16'h3083); "shu": r = mk(16'h3057, 16'h3085);
            "she": r = mk(16'h3057, 16'h3047); "sho": r = mk(16'h3057, 16'h3087);
            "shi": r = mk(16'h3057, 16'h0000);
            "ja":  r = mk(16'h3058, 16'h3083); "ju":  r = mk(16'h3058, 16'h3085);
            "je":  r = mk(16'h3058, 16'h3047); "jo":  r = mk(16'h3058, 16'h3087);
            "ji":  r = mk(16'h3058, 16'h0000);
            "cha": r = mk(16'h3061, 16'h3083); "chu": r = mk(16'h3061, 16'h3085);
            "che": r = mk(16'h3061, 16'h3047); "cho": r = mk(16'h3061, 16'h3087);
            "chi": r = mk(16'h3061, 16'h0000);
            "tsu": r = mk(16'h3064, 16'h0000);
            "fya": r = mk(16'h3075, 16'h3083); "fyu": r = mk(16'h3075, 16'h3085);
            "fyo": r = mk(16'h3075, 16'h3087);
            "vya": r = mk(16'h3094, 16'h3083); "vyu": r = mk(16'h3094, 16'h3085);
            "vyo": r = mk(16'h3094, 16'h3087);
            "xya": r = mk(16'h3083, 16'h0000); "xyu": r = mk(16'h3085, 16'h0000);
            "xyo": r = mk(16'h3087, 16'h0000);
            "lya": r = mk(16'h3083, 16'h0000); "lyu": r = mk(16'h3085, 16'h0000);
            "lyo": r = mk(16'h3087, 16'h0000);
            "xtsu": r = mk(16'h3063, 16'h0000); "ltsu": r = mk(16'h3063, 16'h0000);
            "xtu": r = mk(16'h3063, 16'h0000); "ltu": r = mk(16'h3063, 16'h0000);
            "xwa": r = mk(16'h308E, 16'h0000); "lwa": r = mk(16'h308E, 16'h0000);
            "xa": r = mk(16'h3041, 16'h0000); "xi": r = mk(16'h3043, 16'h0000);
            "xu": r = mk(16'h3045, 16'h0000); "xe": r = mk(16'h3047, 16'h0000);
            "xo": r = mk(16'h3049, 16'h0000);
            "la": r = mk(16'h3041, 16'h0000); "li": r = mk(16'h3043, 16'h0000);
            "lu": r = mk(16'h3045, 16'h0000); "le": r = mk(16'h3047, 16'h0000);
            "lo": r = mk(16'h3049, 16'h0000);
            "ka": r = mk(16'h304B, 16'h0000); "ki": r = mk(16'h304D, 16'h0000);
            "ku": r = mk(16'h304F, 16'h0000); "ke": r = mk(16'h3051, 16'h0000);
            "ko": r = mk(16'h3053, 16'h0000);
            "ga": r = mk(16'h304C, 16'h0000); "gi": r = mk(16'h304E, 16'h0000);
            "gu": r = mk(16'h3050, 16'h0000); "ge": r = mk(16'h3052, 16'h0000);
            "go": r = mk(16'h3054, 16'h0000);
            "sa": r = mk(16'h3055, 16'h0000); "si": r = mk(16'h3057, 16'h0000);
            "su": r = mk(16'h3059, 16'h0000); "se": r = mk(16'h305B, 16'h0000);
            "so": r = mk(16'h305D, 16'h0000);
            "za": r = mk(16'h3056, 16'h0000); "zi": r = mk(16'h3058, 16'h0000);
            "zu": r = mk(16'h305A, 16'h0000); "ze": r = mk(16'h305C, 16'h0000);
            "zo": r = mk(16'h305E, 16'h0000);
            "ta": r = mk(16'h305F, 16'h0000); "ti": r = mk(16'h3061, 16'h0000);
            "tu": r = mk(16'h3064, 16'h0000); "te": r = mk(16'h3066, 16'h0000);
            "to": r = mk(16'h3068, 16'h0000);
            "da": r = mk(16'h3060, 16'h0000); "di": r = mk(16'h3062, 16'h0000);
            "du": r = mk(16'h3065, 16'h0000); "de": r = mk(16'h3067, 16'h0000);
            "do": r = mk(16'h3069, 16'h0000);
            "na": r = mk(16'h306A, 16'h0000); "ni": r = mk(16'h306B, 16'h0000);
            "nu": r = mk(16'h306C, 16'h0000); "ne": r = mk(16'h306D, 16'h0000);
            "no": r = mk(16'h306E, 16'h0000);
            "ha": r = mk(16'h306F, 16'h0000); "hi": r = mk(16'h3072, 16'h0000);
            "hu": r = mk(16'h3075, 16'h0000); "he": r = mk(16'h3078, 16'h0000);
            "ho": r = mk(16'h307B, 16'h0000);
            "ba": r = mk(16'h3070, 16'h0000); "bi": r = mk(16'h3073, 16'h0000);
            "bu": r = mk(16'h3076, 16'h0000); "be": r = mk(16'h3079, 16'h0000);
            "bo": r = mk(16'h307C, 16'h0000);
            "pa": r = mk(16'h3071, 16'h0000); "pi": r = mk(16'h3074, 16'h0000);
            "pu": r = mk(16'h3077, 16'h0000); "pe": r = mk(16'h307A, 16'h0000);
            "po": r = mk(16'h307D, 16'h0000);
            "fa": r = mk(16'h3075, 16'h3041); "fi": r = mk(16'h3075, 16'h3043);
            "fu": r = mk(16'h3075, 16'h0000); "fe": r = mk(16'h3075, 16'h3047);
            "fo": r = mk(16'h3075, 16'h3049);
            "ma": r = mk(16'h307E, 16'h0000); "mi": r = mk(16'h307F, 16'h0000);
            "mu": r = mk(16'h3080, 16'h0000); "me": r = mk(16'h3081, 16'h0000);
            "mo": r = mk(16'h3082, 16'h0000);
            "ya": r = mk(16'h3084, 16'h0000); "yu": r = mk(16'h3086, 16'h0000);
            "yo": r = mk(16'h3088, 16'h0000); "yi": r = mk(16'h3044, 16'h0000);
            "ye": r = mk(16'h3044, 16'h3047);
            "ra": r = mk(16'h3089, 16'h0000); "ri": r = mk(16'h308A, 16'h0000);
            "ru": r = mk(16'h308B, 16'h0000); "re": r = mk(16'h308C, 16'h0000);
            "ro": r = mk(16'h308D, 16'h0000);
            "wa": r = mk(16'h308F, 16'h0000); "wo": r = mk(16'h3092, 16'h0000);
            "wi": r = mk(16'h3046, 16'h3043); "we": r = mk(16'h3046, 16'h3047);
            "wu": r = mk(16'h3046, 16'h0000);
            "va": r = mk(16'h3094, 16'h3041); "vi": r = mk(16'h3094, 16'h3043);
            "vu": r = mk(16'h3094, 16'h0000); "ve": r = mk(16'h3094, 16'h3047);
            "vo": r = mk(16'h3094, 16'h3049);
            "a": r = mk(16'h3042, 16'h0000); "i": r = mk(16'h3044, 16'h0000);
            "u": r = mk(16'h3046, 16'h0000); "e": r = mk(16'h3048, 16'h0000);
            "o": r = mk(16'h304A, 16'h0000);
            "-": r = mk(16'h30FC, 16'h0000); ",": r = mk(16'h3001, 16'h0000);
            ".": r = mk(16'h3002, 16'h0000); "/": r = mk(16'h30FB, 16'h0000);
            "[": r = mk(16'h300C, 16'h0000); "]": r = mk(16'h300D, 16'h0000);
            default: r = '0;
        endcase
        return r;
    endfunction

    // True when the key is a proper prefix of some longer rule.
    function automatic logic rom_prefix(input logic [31:0] key);
        logic p;
        p = 1'b0;
        case (key)
            "k", "g", "s", "j", "z", "c", "t", "d", "n", "h", "b", "p", "m", "r",
            "f", "v", "x", "l", "y", "w": p = 1'b1;
            "ky", "gy", "sy", "jy", "zy", "cy", "ty", "dy", "ny", "hy", "by", "py",
            "my", "ry", "sh", "ch", "ts", "fy", "vy", "xy", "ly", "xt", "lt",
            "xw", "lw": p = 1'b1;
            "xts", "lts": p = 1'b1;
            default: p = 1'b0;
        endcase
        return p;
    endfunction

    // Decides the head of the window; m is the letter count capped at four.
    function automatic settle_t settle(input logic [6:0] c0, input logic [6:0] c1,
                                       input logic [6:0] c2, input logic [6:0] c3,
                                       input logic [2:0] m, input logic fin);
        settle_t     r;
        logic [31:0] key1;
        logic [31:0] key2;
        logic [31:0] key3;
        logic [31:0] key4;
        logic [31:0] keym;
        rom_hit_t    h1;
        rom_hit_t    h2;
        rom_hit_t    h3;
        rom_hit_t    h4;
        r       = '0;
        r.go    = 1'b1;
        r.use_n = 3'd1;
        key1 = {24'd0, 1'b0, c0};
        key2 = {16'd0, 1'b0, c0, 1'b0, c1};
        key3 = {8'd0, 1'b0, c0, 1'b0, c1, 1'b0, c2};
        key4 = {1'b0, c0, 1'b0, c1, 1'b0, c2, 1'b0, c3};
        keym = (m == 3'd1) ? key1 : (m == 3'd2) ? key2 : key3;
        h1 = rom_lookup(key1);
        h2 = rom_lookup(key2);
        h3 = rom_lookup(key3);
        h4 = rom_lookup(key4);
        if (c0 == CH_N && m >= 3'd2 && c1 == CH_N) begin
            if (m == 3'd2 && !fin) begin
                r.go = 1'b0;
            end
            else begin
                r.k0    = KANA_N;
                r.use_n = (m >= 3'd3 && (is_vowel(c2) || c2 == CH_Y)) ? 3'd1 : 3'd2;
            end
        end
        else if (c0 == CH_N && m >= 3'd2 && c1 == CH_APOS) begin
            r.k0    = KANA_N;
            r.use_n = 3'd2;
        end
        else if (c0 == CH_N && m >= 3'd2 && !is_vowel(c1) && c1 != CH_Y) begin
            r.k0 = KANA_N;
        end
        else if (m >= 3'd2 && c0 == c1 && doubles(c0)) begin
            r.k0 = KANA_SOKUON;
        end
        else if (m == 3'd1 && !fin && doubles(c0)) begin
            r.go = 1'b0;
        end
        else if (m >= 3'd4 && h4.hit) begin
            r.k0 = h4.k0; r.k1 = h4.k1; r.use_n = 3'd4;
        end
        else if (m >= 3'd3 && h3.hit) begin
            r.k0 = h3.k0; r.k1 = h3.k1; r.use_n = 3'd3;
        end
        else if (m >= 3'd2 && h2.hit) begin
            r.k0 = h2.k0; r.k1 = h2.k1; r.use_n = 3'd2;
        end
        else if (h1.hit) begin
            r.k0 = h1.k0; r.k1 = h1.k1;
        end
        else if (m < 3'd4 && rom_prefix(keym)) begin
            r.go = 1'b0;
        end
        return r;
    endfunction

endpackage

FILE: rtl/romaji_to_kana_converter.sv
// Results: each code waits in a pending register to learn whether it is the last of its word,
// and only then moves to the output register; this holds for a rejected key's result as well.
// A stalled output holds the back end, while a two-entry queue keeps taking words meanwhile.
// Reset (rst_n, asynchronous, active low) empties window, queue and output, sets reading mode.
module romaji_to_kana_converter
    import rkc_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,      // flush_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // char_code
    input  logic        s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // code_point
    output logic        m_axis_tuser,   // rejected
    output logic        m_axis_tlast
);

    // The user writes the flush mode register only while the block is idle; the block does not enforce it.
    logic flush_mode_reg;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;
    cmd_t q_in;
    cmd_t q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            flush_mode_reg <= 1'b0;
        end
        else if (cfg_we) begin
            flush_mode_reg <= cfg_wdata;
        end
    end

    // The front end folds upper case and sorts each word into letter, flush or rejected key.
    rkc_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (q_in)
    );

    rkc_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    // The back end holds one result back so that it can mark the final one of each word.
    rkc_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .flush_mode    (flush_mode_reg),
        .q_valid       (q_valid),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

FILE: rtl/rkc_front.sv
// Front end: takes input words and classifies them into commands for the queue.
module rkc_front
    import rkc_pkg::*;
(
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_cmd
);

    logic is_upper;
    logic is_lower;
    logic is_mark;

    assign is_upper = s_axis_tdata >= 16'h0041 && s_axis_tdata <= 16'h005a;
    assign is_lower = s_axis_tdata >= 16'h0061 && s_axis_tdata <= 16'h007a;
    assign is_mark  = s_axis_tdata == 16'h002d || s_axis_tdata == 16'h002c ||
                      s_axis_tdata == 16'h002e || s_axis_tdata == 16'h002f ||
                      s_axis_tdata == 16'h005b || s_axis_tdata == 16'h005d ||
                      s_axis_tdata == 16'h0027;

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    always_comb
    begin
        q_cmd.code = s_axis_tdata;
        if (s_axis_tuser) begin
            q_cmd.kind = CMD_FLUSH;
        end
        else if (is_upper) begin
            q_cmd.kind = CMD_LETTER;
            q_cmd.code = s_axis_tdata | 16'h0020;
        end
        else if (is_lower || is_mark) begin
            q_cmd.kind = CMD_LETTER;
        end
        else begin
            q_cmd.kind = CMD_REJECT;
        end
    end

endmodule

FILE: rtl/rkc_queue.sv
// Short command queue between the front end and the back end.
module rkc_queue
    import rkc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic valid,
    output cmd_t head
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t            entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   fill_reg;
    logic            do_push;
    logic            do_pop;

    assign full    = fill_reg == CW'(QUEUE_DEPTH);
    assign valid   = fill_reg != '0;
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/rkc_back.sv
// Back end: lookahead window, rule sequencer, held result and output register.
module rkc_back
    import rkc_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        flush_mode,
    input  logic        q_valid,
    input  cmd_t        q_head,
    output logic        q_pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tuser,
    output logic        m_axis_tlast
);

    localparam int IW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SETTLE = 6'b000010,
        ST_K0     = 6'b000100,
        ST_K1     = 6'b001000,
        ST_TAIL   = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    typedef enum logic [1:0] {
        WIN_HOLD   = 2'd0,
        WIN_APPEND = 2'd1,
        WIN_SHIFT  = 2'd2
    } win_op_t;

    state_t        state_reg, state_next;
    logic [6:0]    win_reg [WINDOW_DEPTH];
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] tail_idx_reg, tail_idx_next;
    logic          fin_reg, fin_next;
    logic [15:0]   k0_reg, k0_next;
    logic [15:0]   k1_reg, k1_next;
    logic [2:0]    use_reg, use_next;
    logic          pend_valid_reg;
    logic [15:0]   pend_code_reg;
    logic          pend_rej_reg;
    logic          out_valid_reg;
    logic [15:0]   out_code_reg;
    logic          out_rej_reg;
    logic          out_last_reg;
    win_op_t       win_op;
    settle_t       st;
    logic [2:0]    m_sat;
    logic          emit_req;
    logic [15:0]   emit_code;
    logic          emit_rej;
    logic          fin_req;
    logic          out_free;
    logic          emit_ok;
    logic          fire_emit;
    logic          fire_fin;

    assign m_sat     = (count_reg >= CW'(4)) ? 3'd4 : 3'(count_reg);
    assign st        = settle(win_reg[0], win_reg[1], win_reg[2], win_reg[3], m_sat, fin_reg);
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign emit_ok   = !pend_valid_reg || out_free;
    assign fire_emit = emit_req && emit_ok;
    assign fire_fin  = fin_req && emit_ok;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        tail_idx_next = tail_idx_reg;
        fin_next      = fin_reg;
        k0_next       = k0_reg;
        k1_next       = k1_reg;
        use_next      = use_reg;
        win_op        = WIN_HOLD;
        emit_req      = 1'b0;
        emit_code     = '0;
        emit_rej      = 1'b0;
        fin_req       = 1'b0;
        q_pop         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid) begin
                    case (q_head.kind)
                        CMD_REJECT:
                        begin
                            emit_req  = 1'b1;
                            emit_code = q_head.code;
                            emit_rej  = 1'b1;
                            if (emit_ok) begin
                                q_pop      = 1'b1;
                                state_next = ST_DONE;
                            end
                        end
                        CMD_LETTER:
                        begin
                            q_pop      = 1'b1;
                            fin_next   = 1'b0;
                            state_next = ST_SETTLE;
                            if (count_reg < CW'(WINDOW_DEPTH)) begin
                                win_op     = WIN_APPEND;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            q_pop      = 1'b1;
                            fin_next   = 1'b1;
                            state_next = ST_SETTLE;
                        end
                    endcase
                end
            end
            ST_SETTLE:
            begin
                if (count_reg == '0) begin
                    state_next = ST_DONE;
                end
                else if (st.go) begin
                    k0_next    = st.k0;
                    k1_next    = st.k1;
                    use_next   = st.use_n;
                    state_next = ST_K0;
                end
                else if (fin_reg) begin
                    tail_idx_next = '0;
                    state_next    = ST_TAIL;
                end
                else begin
                    state_next = ST_DONE;
                end
            end
            ST_K0:
            begin
                if (k0_reg != '0) begin
                    emit_req  = 1'b1;
                    emit_code = k0_reg;
                    if (emit_ok) begin
                        state_next = ST_K1;
                    end
                end
                else begin
                    state_next = ST_K1;
                end
            end
            ST_K1:
            begin
                emit_req  = k1_reg != '0;
                emit_code = k1_reg;
                if (k1_reg == '0 || emit_ok) begin
                    win_op     = WIN_SHIFT;
                    count_next = (CW'(use_reg) > count_reg) ? '0 : count_reg - CW'(use_reg);
                    state_next = ST_SETTLE;
                end
            end
            ST_TAIL:
            begin
                if (count_reg == CW'(1) && win_reg[0] == CH_N) begin
                    // A lone n at the end of a word always reads as the syllabic n.
                    emit_req  = 1'b1;
                    emit_code = KANA_N;
                    if (emit_ok) begin
                        count_next = '0;
                        state_next = ST_DONE;
                    end
                end
                else if (flush_mode && tail_idx_reg < count_reg) begin
                    emit_req  = 1'b1;
                    emit_code = {9'd0, win_reg[tail_idx_reg[IW-1:0]]};
                    if (emit_ok) begin
                        tail_idx_next = tail_idx_reg + 1'b1;
                    end
                end
                else begin
                    count_next = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                fin_req = 1'b1;
                if (emit_ok) begin
                    if (fin_reg) begin
                        count_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            tail_idx_reg   <= '0;
            fin_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            tail_idx_reg <= tail_idx_next;
            fin_reg      <= fin_next;
            if (fire_emit) begin
                pend_valid_reg <= 1'b1;
            end
            else if (fire_fin) begin
                pend_valid_reg <= 1'b0;
            end
            if ((fire_emit || fire_fin) && pend_valid_reg) begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k0_reg  <= k0_next;
        k1_reg  <= k1_next;
        use_reg <= use_next;
        if (fire_emit) begin
            pend_code_reg <= emit_code;
            pend_rej_reg  <= emit_rej;
        end
        if ((fire_emit || fire_fin) && pend_valid_reg) begin
            out_code_reg <= pend_code_reg;
            out_rej_reg  <= pend_rej_reg;
            out_last_reg <= fire_fin;
        end
        case (win_op)
            WIN_APPEND:
            begin
                win_reg[count_reg[IW-1:0]] <= q_head.code[6:0];
            end
            WIN_SHIFT:
            begin
                for (int i = 0; i < WINDOW_DEPTH; i++) begin
                    if (i + int'(use_reg) < WINDOW_DEPTH) begin
                        win_reg[i] <= win_reg[IW'(i + int'(use_reg))];
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_code_reg;
    assign m_axis_tuser  = out_rej_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

FILE: rtl/rkc_checker.sv
// Port-level checker for the romaji to kana converter, bound to the top level.
module rkc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("rejected key not marked last");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            (m_axis_tdata[15:8] == 8'h30 || m_axis_tdata[15:7] == 9'd0))
        else $error("accepted result is neither kana nor a letter");

    a_reject_not_letter: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |->
            !(m_axis_tdata >= 16'h0061 && m_axis_tdata <= 16'h007a))
        else $error("lower-case letter reported as rejected");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind romaji_to_kana_converter rkc_checker u_rkc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

FILE: dv/romaji_to_kana_converter_tb.sv
// Self-checking testbench for the romaji to kana converter: directed table, display-mode words, then random words.
`timescale 1ns / 1ps

module romaji_to_kana_converter_tb
    import rkc_pkg::*;
();

    // Input word kinds as carried on s_axis_tuser.
    localparam logic KIND_KEY   = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    localparam logic MODE_READING = 1'b0;
    localparam logic MODE_DISPLAY = 1'b1;

    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [15:0] code_point;
        logic        rejected;
        logic        last;
    } kana_out_t;

    // One row of the directed table; has_exp marks rows whose result is typed in.
    typedef struct {
        logic      kind;
        int        ch;
        bit        has_exp;
        kana_out_t exp;
    } key_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // char_code
    logic        s_axis_tuser;   // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;   // code_point
    logic        m_axis_tuser;   // rejected
    logic        m_axis_tlast;

    romaji_to_kana_converter uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Predictor state: our own copy of the window and of the mode register.
    logic [6:0] win[4];
    int         win_n;
    logic       mode_q;
    kana_out_t  kana_due[$];

    int  mismatches;
    int  cycles = 0;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_recv;
    int  hold_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Rule table lookup by letters; returns hit with the two kana (0 for none).
    function automatic bit rule_find(input string s, output logic [15:0] a,
                                     output logic [15:0] b);
        a = 16'h0;
        b = 16'h0;
        case (s)
            "sha": begin a = 16'h3057; b = 16'h3083; end
            "shu": begin a = 16'h3057; b = 16'h3085; end
            "she": begin a = 16'h3057; b = 16'h3047; end
            "sho": begin a = 16'h3057; b = 16'h3087; end
            "shi": a = 16'h3057;
            "ja": begin a = 16'h3058; b = 16'h3083; end
            "ju": begin a = 16'h3058; b = 16'h3085; end
            "je": begin a = 16'h3058; b = 16'h3047; end
            "jo": begin a = 16'h3058; b = 16'h3087; end
            "ji": a = 16'h3058;
            "cha": begin a = 16'h3061; b = 16'h3083; end
            "chu": begin a = 16'h3061; b = 16'h3085; end
            "che": begin a = 16'h3061; b = 16'h3047; end
            "cho": begin a = 16'h3061; b = 16'h3087; end
            "chi": a = 16'h3061;
            "tsu": a = 16'h3064;
            "fya": begin a = 16'h3075; b = 16'h3083; end
            "fyu": begin a = 16'h3075; b = 16'h3085; end
            "fyo": begin a = 16'h3075; b = 16'h3087; end
            "vya": begin a = 16'h3094; b = 16'h3083; end
            "vyu": begin a = 16'h3094; b = 16'h3085; end
            "vyo": begin a = 16'h3094; b = 16'h3087; end
            "xya", "lya": a = 16'h3083;
            "xyu", "lyu": a = 16'h3085;
            "xyo", "lyo": a = 16'h3087;
            "xtsu", "ltsu", "xtu", "ltu": a = 16'h3063;
            "xwa", "lwa": a = 16'h308E;
            "xa", "la": a = 16'h3041;
            "xi", "li": a = 16'h3043;
            "xu", "lu": a = 16'h3045;
            "xe", "le": a = 16'h3047;
            "xo", "lo": a = 16'h3049;
            "ka": a = 16'h304B; "ki": a = 16'h304D; "ku": a = 16'h304F;
            "ke": a = 16'h3051; "ko": a = 16'h3053;
            "ga": a = 16'h304C; "gi": a = 16'h304E; "gu": a = 16'h3050;
            "ge": a = 16'h3052; "go": a = 16'h3054;
            "sa": a = 16'h3055; "si": a = 16'h3057; "su": a = 16'h3059;
            "se": a = 16'h305B; "so": a = 16'h305D;
            "za": a = 16'h3056; "zi": a = 16'h3058; "zu": a = 16'h305A;
            "ze": a = 16'h305C; "zo": a = 16'h305E;
            "ta": a = 16'h305F; "ti": a = 16'h3061; "tu": a = 16'h3064;
            "te": a = 16'h3066; "to": a = 16'h3068;
            "da": a = 16'h3060; "di": a = 16'h3062; "du": a = 16'h3065;
            "de": a = 16'h3067; "do": a = 16'h3069;
            "na": a = 16'h306A; "ni": a = 16'h306B; "nu": a = 16'h306C;
            "ne": a = 16'h306D; "no": a = 16'h306E;
            "ha": a = 16'h306F; "hi": a = 16'h3072; "hu": a = 16'h3075;
            "he": a = 16'h3078; "ho": a = 16'h307B;
            "ba": a = 16'h3070; "bi": a = 16'h3073; "bu": a = 16'h3076;
            "be": a = 16'h3079; "bo": a = 16'h307C;
            "pa": a = 16'h3071; "pi": a = 16'h3074; "pu": a = 16'h3077;
            "pe": a = 16'h307A; "po": a = 16'h307D;
            "fa": begin a = 16'h3075; b = 16'h3041; end
            "fi": begin a = 16'h3075; b = 16'h3043; end
            "fu": a = 16'h3075;
            "fe": begin a = 16'h3075; b = 16'h3047; end
            "fo": begin a = 16'h3075; b = 16'h3049; end
            "ma": a = 16'h307E; "mi": a = 16'h307F; "mu": a = 16'h3080;
            "me": a = 16'h3081; "mo": a = 16'h3082;
            "ya": a = 16'h3084; "yu": a = 16'h3086; "yo": a = 16'h3088;
            "yi": a = 16'h3044;
            "ye": begin a = 16'h3044; b = 16'h3047; end
            "ra": a = 16'h3089; "ri": a = 16'h308A; "ru": a = 16'h308B;
            "re": a = 16'h308C; "ro": a = 16'h308D;
            "wa": a = 16'h308F; "wo": a = 16'h3092;
            "wi": begin a = 16'h3046; b = 16'h3043; end
            "we": begin a = 16'h3046; b = 16'h3047; end
            "wu": a = 16'h3046;
            "va": begin a = 16'h3094; b = 16'h3041; end
            "vi": begin a = 16'h3094; b = 16'h3043; end
            "vu": a = 16'h3094;
            "ve": begin a = 16'h3094; b = 16'h3047; end
            "vo": begin a = 16'h3094; b = 16'h3049; end
            "a": a = 16'h3042; "i": a = 16'h3044; "u": a = 16'h3046;
            "e": a = 16'h3048; "o": a = 16'h304A;
            "-": a = 16'h30FC; ",": a = 16'h3001; ".": a = 16'h3002;
            "/": a = 16'h30FB; "[": a = 16'h300C; "]": a = 16'h300D;
            default: return 1'b0;
        endcase
        // A row matched above is a hit; the consonant + y + vowel rows are left to rule_hit.
        return 1'b1;
    endfunction

    // Full lookup including the consonant-y-vowel family, which is regular.
    function automatic bit rule_hit(input string s, output logic [15:0] a,
                                    output logic [15:0] b);
        logic [15:0] base;
        string       cons;
        if (rule_find(s, a, b))
            return 1'b1;
        if (s.len() != 3 || s[1] != "y")
            return 1'b0;
        cons = s.substr(0, 0);
        case (cons)
            "k": base = 16'h304D; "g": base = 16'h304E; "s": base = 16'h3057;
            "j", "z": base = 16'h3058; "c", "t": base = 16'h3061;
            "d": base = 16'h3062; "n": base = 16'h306B; "h": base = 16'h3072;
            "b": base = 16'h3073; "p": base = 16'h3074; "m": base = 16'h307F;
            "r": base = 16'h308A;
            default: return 1'b0;
        endcase
        case (s[2])
            "a": b = 16'h3083; "i": b = 16'h3043; "u": b = 16'h3085;
            "e": b = 16'h3047; "o": b = 16'h3087;
            default: return 1'b0;
        endcase
        a = base;
        return 1'b1;
    endfunction

    function automatic bit vowel_ch(input logic [6:0] c);
        return c inside {"a", "i", "u", "e", "o"};
    endfunction

    function automatic bit doubling_ch(input logic [6:0] c);
        return c >= "a" && c <= "z" && !vowel_ch(c) && c != CH_N;
    endfunction

    function automatic bit rule_prefix(input string s);
        case (s)
            "k", "g", "s", "j", "z", "c", "t", "d", "n", "h", "b", "p", "m", "r",
            "f", "v", "x", "l", "y", "w",
            "ky", "gy", "sy", "jy", "zy", "cy", "ty", "dy", "ny", "hy", "by", "py",
            "my", "ry", "sh", "ch", "ts", "fy", "vy", "xy", "ly", "xt", "lt",
            "xw", "lw", "xts", "lts": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void push_kana(input logic [15:0] code, input logic rej);
        kana_out_t r;
        r.code_point = code;
        r.rejected   = rej;
        r.last       = 1'b0;
        kana_due.insert(kana_due.size(), r);
    endfunction

    // Decides the window head repeatedly; returns 1 if letters are left waiting.
    function automatic bit resolve_window(input bit fin);
        logic [15:0] a;
        logic [15:0] b;
        int          eat;
        int          len;
        bit          done;
        string       s;
        while (win_n > 0)
        begin
            a = 16'h0;
            b = 16'h0;
            eat = 1;
            done = 1'b0;
            if (win[0] == CH_N && win_n >= 2 && win[1] == CH_N)
            begin
                if (win_n == 2 && !fin)
                    return 1'b1;
                a = KANA_N;
                eat = (win_n >= 3 && (vowel_ch(win[2]) || win[2] == CH_Y)) ? 1 : 2;
                done = 1'b1;
            end
            else if (win[0] == CH_N && win_n >= 2 && win[1] == CH_APOS)
            begin
                a = KANA_N;
                eat = 2;
                done = 1'b1;
            end
            else if (win[0] == CH_N && win_n >= 2 && !vowel_ch(win[1]) && win[1] != CH_Y)
            begin
                a = KANA_N;
                done = 1'b1;
            end
            else if (win_n >= 2 && win[0] == win[1] && doubling_ch(win[0]))
            begin
                a = KANA_SOKUON;
                done = 1'b1;
            end
            else if (win_n == 1 && !fin && doubling_ch(win[0]))
                return 1'b1;
            if (!done)
            begin
                for (len = win_n; len >= 1 && !done; len--)
                begin
                    s = "";
                    for (int i = 0; i < len; i++)
                        s = {s, string'(8'(win[i]))};
                    if (rule_hit(s, a, b))
                    begin
                        eat = len;
                        done = 1'b1;
                    end
                end
            end
            if (!done)
            begin
                s = "";
                for (int i = 0; i < win_n; i++)
                    s = {s, string'(8'(win[i]))};
                // An incomplete rule prefix waits; anything else is a stray letter.
                if (win_n < 4 && rule_prefix(s))
                    return 1'b1;
            end
            if (a != 16'h0)
                push_kana(a, 1'b0);
            if (b != 16'h0)
                push_kana(b, 1'b0);
            for (int i = 0; i + eat < win_n; i++)
                win[i] = win[i + eat];
            win_n -= eat;
        end
        return 1'b0;
    endfunction

    // Works out the results of one accepted word and queues them.
    task automatic predict_kana(input logic kind, input logic [15:0] ch);
        int  first;
        bit  key_ok;
        logic [15:0] c;
        first = kana_due.size();
        c = ch;
        if (kind == KIND_KEY)
        begin
            key_ok = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
                     c inside {"-", ",", ".", "/", "[", "]", "'"};
            if (!key_ok)
                push_kana(c, 1'b1);
            else
            begin
                if (c >= "A" && c <= "Z")
                    c = c + 16'h0020;
                if (win_n < 4)
                begin
                    win[win_n] = c[6:0];
                    win_n++;
                end
                void'(resolve_window(1'b0));
            end
        end
        else
        begin
            if (resolve_window(1'b1))
            begin
                if (win_n == 1 && win[0] == CH_N)
                    push_kana(KANA_N, 1'b0);
                else if (mode_q == MODE_DISPLAY)
                    for (int i = 0; i < win_n; i++)
                        push_kana({9'd0, win[i]}, 1'b0);
            end
            win_n = 0;
        end
        if (kana_due.size() > first)
            kana_due[kana_due.size() - 1].last = 1'b1;
    endtask

    // Receiver: random stalls, plus a long hold-off when asked.
    always @(posedge clk)
    begin
        if (hold_recv)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (hold_recv)
            hold_cycles <= hold_cycles + 1;
    end

    // Checker: every accepted word against the oldest expectation.
    always @(posedge clk)
    begin
        kana_out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (kana_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word code=%h rej=%b last=%b",
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end
            else
            begin
                want = kana_due.pop_front();
                if (want.code_point !== m_axis_tdata || want.rejected !== m_axis_tuser ||
                    want.last !== m_axis_tlast)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected code=%h rej=%b last=%b, got %h %b %b",
                                 want.code_point, want.rejected, want.last,
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Drives one word, waits for it to be taken and queues its predicted results.
    task automatic send_word(input logic kind, input logic [15:0] ch);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= ch;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_kana(kind, ch);
    endtask

    task automatic drain_wait();
        s_axis_tvalid <= 1'b0;
        while (kana_due.size() != 0)
            @(posedge clk);
        // Words that give no result may still be in flight.
        repeat (40) @(posedge clk);
    endtask

    task automatic write_mode(input logic v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        mode_q = v;
    endtask

    // A well-formed syllable or a noisy key, typed as a string.
    function automatic string pick_syllable();
        string pool[] = '{"ka", "shi", "tsu", "chu", "kyo", "nya", "n", "nn", "kk", "tt",
                          "xtsu", "ltu", "fa", "ve", "wo", "ye", "n'", "ja", "ri", "-",
                          ",", ".", "/", "[", "]", "a", "e", "q", "pp", "ryu", "xwa"};
        return pool[$urandom_range(pool.size() - 1)];
    endfunction

    task automatic random_phase(input int words);
        string       syl;
        logic [15:0] ch;
        int          sent;
        sent = 0;
        while (sent < words)
        begin
            case ($urandom_range(9))
                0: begin
                    send_word(KIND_FLUSH, 16'($urandom));
                    sent++;
                end
                1: begin
                    // Any 16-bit code, mostly rejected keys.
                    send_word(KIND_KEY, 16'($urandom));
                    sent++;
                end
                2: begin
                    ch = 16'($urandom_range("z", "a"));
                    send_word(KIND_KEY, $urandom_range(1) ? ch - 16'h20 : ch);
                    sent++;
                end
                default: begin
                    syl = pick_syllable();
                    for (int i = 0; i < syl.len(); i++)
                    begin
                        ch = {8'd0, syl[i]};
                        if (ch >= "a" && ch <= "z" && $urandom_range(3) == 0)
                            ch -= 16'h20;
                        send_word(KIND_KEY, ch);
                        sent++;
                    end
                end
            endcase
        end
    endtask

    initial
    begin
        key_row_t rows[$];
        key_row_t row;
        string    txt;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 16'h0;
        s_axis_tuser  = KIND_KEY;
        mismatches    = 0;
        hold_recv     = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        win_n         = 0;
        mode_q        = MODE_READING;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: extremes, rejected keys, empty flush, n rules and held letters.
        rows.insert(rows.size(), '{KIND_FLUSH, 16'hFFFF, 1'b0, '0});
        rows.insert(rows.size(), '{KIND_KEY, 16'h0000, 1'b1, '{16'h0000, 1'b1, 1'b1}});
        rows.insert(rows.size(), '{KIND_KEY, 16'hFFFF, 1'b1, '{16'hFFFF, 1'b1, 1'b1}});
        rows.insert(rows.size(), '{KIND_KEY, 16'h00E1, 1'b1, '{16'h00E1, 1'b1, 1'b1}});
        rows.insert(rows.size(), '{KIND_KEY, "A", 1'b1, '{16'h3042, 1'b0, 1'b1}});
        rows.insert(rows.size(), '{KIND_KEY, "q", 1'b0, '0});
        rows.insert(rows.size(), '{KIND_FLUSH, 16'h0, 1'b0, '0});
        txt = "nnakkaN'ashi";
        for (int i = 0; i < txt.len(); i++)
            rows.insert(rows.size(), '{KIND_KEY, txt[i], 1'b0, '0});
        rows.insert(rows.size(), '{KIND_KEY, "n", 1'b0, '0});
        rows.insert(rows.size(), '{KIND_FLUSH, 16'h0, 1'b0, '0});
        rows.insert(rows.size(), '{KIND_KEY, "k", 1'b0, '0});
        rows.insert(rows.size(), '{KIND_KEY, "y", 1'b0, '0});
        rows.insert(rows.size(), '{KIND_FLUSH, 16'h0, 1'b0, '0});
        rows.insert(rows.size(), '{KIND_KEY, "n", 1'b0, '0});
        rows.insert(rows.size(), '{KIND_KEY, "n", 1'b0, '0});
        rows.insert(rows.size(), '{KIND_FLUSH, 16'h0, 1'b0, '0});
        foreach (rows[i])
        begin
            row = rows[i];
            send_word(row.kind, 16'(row.ch));
            if (row.has_exp)
            begin
                // Typed-in rows replace what the predictor just queued.
                kana_due.delete(kana_due.size() - 1);
                kana_due.insert(kana_due.size(), row.exp);
            end
        end
        drain_wait();

        // Display mode: pending letters come out at flush.
        write_mode(MODE_DISPLAY);
        txt = "kyxts";
        for (int i = 0; i < 2; i++)
            send_word(KIND_KEY, {8'd0, txt[i]});
        send_word(KIND_FLUSH, 16'h0);
        for (int i = 2; i < 5; i++)
            send_word(KIND_KEY, {8'd0, txt[i]});
        send_word(KIND_FLUSH, 16'h0);
        drain_wait();

        // Random phases with the idling patterns, switching the mode between them.
        write_mode(MODE_READING);
        random_phase(80);
        drain_wait();
        write_mode(MODE_DISPLAY);
        send_idle_pct = 50;
        random_phase(80);
        drain_wait();
        send_idle_pct = 0;
        recv_stall_pct = 50;
        random_phase(80);
        drain_wait();
        write_mode(MODE_READING);
        send_idle_pct = 32;
        recv_stall_pct = 32;
        random_phase(80);

        // Long receiver hold-off while words keep coming, so the input backs up.
        drain_wait();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_recv = 1'b1;
        fork
            random_phase(40);
            begin
                while (hold_cycles < 300)
                    @(posedge clk);
                hold_recv = 1'b0;
            end
        join
        drain_wait();
        write_mode(MODE_DISPLAY);
        random_phase(40);
        send_word(KIND_FLUSH, 16'h0);
        drain_wait();

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: romaji_to_kana_converter.f
rtl/rkc_pkg.sv
rtl/rkc_front.sv
rtl/rkc_queue.sv
rtl/rkc_back.sv
rtl/romaji_to_kana_converter.sv
rtl/rkc_checker.sv
dv/romaji_to_kana_converter_tb.sv
